// File: hdl/step_dir_pulse_generator_macros.svh
// Assertion macros shared by the pulse generator modules.
`ifndef STEP_DIR_PULSE_GENERATOR_MACROS_SVH
`define STEP_DIR_PULSE_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SDPG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SDPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sdpg_pkg.sv
// Package: shared types and constants of the step/direction pulse generator.
`default_nettype none
package sdpg_pkg;

   localparam int FIELD_BITS    = 32;
   localparam int CLOCK_BITS    = 30;
   localparam int PRESC_BITS    = 16;
   localparam int PROD_BITS     = PRESC_BITS + 1 + FIELD_BITS;
   localparam int DIV_CNT_BITS  = 5;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = CLOCK_BITS;

   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST      = DIV_CNT_BITS'(CLOCK_BITS - 1);
   localparam logic [CLOCK_BITS-1:0]   CLOCK_RESET   = 30'd180000000;
   localparam logic [31:0]             PERIOD_RESET_WIDE = 32'h0000_FFFF;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMER_CLOCK = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRESCALER   = 1'd1;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_SEND = 2'd1,
      ACT_FREQ = 2'd2,
      ACT_STOP = 2'd3
   } action_type;

   typedef struct packed {
      action_type                     action;
      logic [FIELD_BITS-1:0]          step_count;
      logic                           direction;
      logic signed [FIELD_BITS-1:0]   frequency_hz;
   } req_item_type;

   typedef struct packed {
      logic                  pulse_level;
      logic                  direction_level;
      logic                  busy_flag;
      logic [FIELD_BITS-1:0] steps_left;
      logic                  pulse_event;
   } rsp_item_type;

   typedef struct packed {
      logic exec;
      logic mul;
      logic div_step;
      logic fin;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_status_type;

endpackage
`default_nettype wire

// File: hdl/sdpg_if.sv
// Interfaces: request, response and register-write channels.
`default_nettype none
interface sdpg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] step_count;
   logic        direction;
   logic signed [31:0] frequency_hz;
   modport source (output valid, action, step_count, direction, frequency_hz, input ready);
   modport sink   (input valid, action, step_count, direction, frequency_hz, output ready);
endinterface

interface sdpg_rsp_if;
   logic        valid;
   logic        ready;
   logic        pulse_level;
   logic        direction_level;
   logic        busy_flag;
   logic [31:0] steps_left;
   logic        pulse_event;
   modport source (output valid, pulse_level, direction_level, busy_flag, steps_left,
                   pulse_event, input ready);
   modport sink   (input valid, pulse_level, direction_level, busy_flag, steps_left,
                   pulse_event, output ready);
endinterface

interface sdpg_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [29:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/sdpg_ctrl.sv
// Controller: handshakes, result slot and sequencing of the period division.
`default_nettype none
`include "step_dir_pulse_generator_macros.svh"
module sdpg_ctrl
   import sdpg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.exec     = accept;
      cmd.mul      = (state_ff == S_MUL);
      cmd.div_step = (state_ff == S_DIV);
      cmd.fin      = (state_ff == S_FIN) && out_free;
      cmd.load_out = (accept && !status.need_div) || cmd.fin;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && status.need_div) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (status.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result is only written into a free slot
   `SDPG_ASSERT_SAME(a_load_free, cmd.load_out, out_free, "result slot overwritten")
   // a nonzero frequency holds the request side until the divide is done
   `SDPG_ASSERT_NEXT(a_div_start, accept && status.need_div,
                     state_ff == S_MUL && !req_ready, "divide did not start")
   `SDPG_ASSERT_NEXT(a_div_end, state_ff == S_DIV && status.div_last,
                     state_ff == S_FIN, "divide did not finish")

endmodule
`default_nettype wire

// File: hdl/sdpg_datapath.sv
// Datapath: counters, run state, period divider and result register.
`default_nettype none
`include "step_dir_pulse_generator_macros.svh"
module sdpg_datapath
   import sdpg_pkg::*;
#(
   parameter int STEP_BITS   = 32,
   parameter int PERIOD_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   input  wire req_item_type             req_item,
   input  wire dp_cmd_type               cmd,
   output dp_status_type                 status,
   output rsp_item_type                  rsp_item
);

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(PERIOD_RESET_WIDE);
   localparam logic [31:0]            PERIOD_MAX32 = 32'((64'd1 << PERIOD_BITS) - 64'd1);
   localparam logic [PERIOD_BITS-1:0] PERIOD_ONE   = PERIOD_BITS'(1);

   // configuration
   logic [CLOCK_BITS-1:0]   clock_hz_ff;
   logic [PRESC_BITS-1:0]   presc_ff;

   // run state
   logic [PRESC_BITS-1:0]   presc_cnt_ff, presc_cnt_in;
   logic [PERIOD_BITS-1:0]  period_cnt_ff, period_cnt_in;
   logic [PERIOD_BITS-1:0]  period_ff, period_in;
   logic [STEP_BITS-1:0]    remain_ff, remain_in;
   logic                    busy_ff, busy_in;
   logic                    run_ff, run_in;
   logic                    dir_ff, dir_in;
   logic                    event_in;

   // divider
   logic [FIELD_BITS-1:0]   mag_ff, mag_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic [CLOCK_BITS-1:0]   quo_ff, quo_in;
   logic [CLOCK_BITS-1:0]   div_rem_ff, div_rem_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;

   logic [FIELD_BITS-1:0]   freq_raw;
   logic                    freq_neg;
   logic [FIELD_BITS-1:0]   freq_mag;
   logic [STEP_BITS-1:0]    send_n;
   logic [STEP_BITS-1:0]    remain_dec;
   logic [PERIOD_BITS-1:0]  period_adv;
   logic [PRESC_BITS:0]     presc_p1;
   logic [CLOCK_BITS:0]     trial;
   logic                    trial_ge;
   logic [31:0]             quo_m1;
   logic [PERIOD_BITS-1:0]  period_sat;

   assign freq_raw = req_item.frequency_hz;
   assign freq_neg = freq_raw[FIELD_BITS-1];
   assign freq_mag = freq_neg ? (~freq_raw + FIELD_BITS'(1)) : freq_raw;
   assign send_n   = req_item.step_count[STEP_BITS-1:0];

   assign status.need_div = (req_item.action == ACT_FREQ) && (freq_raw != '0);
   assign status.div_last = (div_cnt_ff == DIV_LAST);

   assign remain_dec = (remain_ff != '0) ? remain_ff - STEP_BITS'(1) : remain_ff;
   assign period_adv = (period_cnt_ff >= period_ff) ? '0 : period_cnt_ff + PERIOD_BITS'(1);

   // one restoring step: remainder stays below the divisor and below 2^30
   assign presc_p1 = {1'b0, presc_ff} + (PRESC_BITS + 1)'(1);
   assign trial    = {div_rem_ff, quo_ff[CLOCK_BITS-1]};
   assign trial_ge = PROD_BITS'(trial) >= prod_ff;

   // period = quotient - 1, at least 1, saturated to the counter width
   assign quo_m1 = 32'(quo_ff) - 32'd1;
   always_comb begin
      if (quo_ff <= CLOCK_BITS'(1)) begin
         period_sat = PERIOD_ONE;
      end else if (quo_m1 > PERIOD_MAX32) begin
         period_sat = PERIOD_MAX32[PERIOD_BITS-1:0];
      end else begin
         period_sat = quo_m1[PERIOD_BITS-1:0];
      end
   end

   always_comb begin
      presc_cnt_in  = presc_cnt_ff;
      period_cnt_in = period_cnt_ff;
      period_in     = period_ff;
      remain_in     = remain_ff;
      busy_in       = busy_ff;
      run_in        = run_ff;
      dir_in        = dir_ff;
      event_in      = 1'b0;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      quo_in        = quo_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;

      if (cmd.exec) begin
         case (req_item.action)
            ACT_TICK: begin
               if (run_ff) begin
                  if (presc_cnt_ff >= presc_ff) begin
                     presc_cnt_in  = '0;
                     period_cnt_in = period_adv;
                     if (period_adv == (period_ff >> 1)) begin
                        event_in = 1'b1;
                        if (busy_ff) begin
                           remain_in = remain_dec;
                           if (remain_dec == '0) begin
                              run_in  = 1'b0;
                              busy_in = 1'b0;
                           end
                        end
                     end
                  end else begin
                     presc_cnt_in = presc_cnt_ff + PRESC_BITS'(1);
                  end
               end
            end
            ACT_SEND: begin
               if (send_n != '0 && !busy_ff) begin
                  busy_in   = 1'b1;
                  remain_in = send_n;
                  dir_in    = req_item.direction;
                  run_in    = 1'b1;
               end
            end
            ACT_FREQ: begin
               dir_in = !freq_neg;
               mag_in = freq_mag;
               if (freq_raw == '0) begin
                  run_in = 1'b0;
               end
            end
            ACT_STOP: begin
               run_in    = 1'b0;
               remain_in = '0;
               busy_in   = 1'b0;
            end
            default: begin
               run_in = run_ff;
            end
         endcase
      end

      if (cmd.mul) begin
         prod_in    = PROD_BITS'(presc_p1) * PROD_BITS'(mag_ff);
         quo_in     = clock_hz_ff;
         div_rem_in = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         quo_in     = {quo_ff[CLOCK_BITS-2:0], trial_ge};
         div_rem_in = trial_ge ? CLOCK_BITS'(trial - prod_ff[CLOCK_BITS:0])
                               : trial[CLOCK_BITS-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_BITS'(1);
      end

      if (cmd.fin) begin
         period_in = period_sat;
         run_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff   <= CLOCK_RESET;
         presc_ff      <= '0;
         presc_cnt_ff  <= '0;
         period_cnt_ff <= '0;
         period_ff     <= PERIOD_RESET;
         remain_ff     <= '0;
         busy_ff       <= 1'b0;
         run_ff        <= 1'b0;
         dir_ff        <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         if (csr_write && csr_index == CSR_TIMER_CLOCK) begin
            clock_hz_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_PRESCALER) begin
            presc_ff <= csr_data[PRESC_BITS-1:0];
         end
         presc_cnt_ff  <= presc_cnt_in;
         period_cnt_ff <= period_cnt_in;
         period_ff     <= period_in;
         remain_ff     <= remain_in;
         busy_ff       <= busy_in;
         run_ff        <= run_in;
         dir_ff        <= dir_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      div_rem_ff <= div_rem_in;
      if (cmd.load_out) begin
         rsp_item.pulse_level     <= run_in && (period_cnt_in < (period_in >> 1));
         rsp_item.direction_level <= dir_in;
         rsp_item.busy_flag       <= busy_in;
         rsp_item.steps_left      <= FIELD_BITS'(remain_in);
         rsp_item.pulse_event     <= event_in;
      end
   end

   `SDPG_ASSERT_SAME(a_busy_count, busy_ff, remain_ff != '0, "busy with no steps left")
   `SDPG_ASSERT_SAME(a_period_nz, 1'b1, period_ff != '0, "period register is zero")

endmodule
`default_nettype wire

// File: hdl/step_dir_pulse_generator.sv
// Top level: step/direction pulse generator, controller plus datapath.
//
//   channel  dir  transfer carries
//   req_     in   action, step_count, direction, frequency_hz
//   rsp_     out  pulse_level, direction_level, busy_flag, steps_left, pulse_event
//   csr_     in   index (0 timer clock hz, 1 prescaler), data
//
// Tick, send-steps, stop and zero-frequency items skip the divider; a new
// item is taken every cycle while the result register drains.
// A nonzero set-frequency item runs one multiply of (prescaler+1)
// by |f|, then a 30-step restoring divide of the clock register, one
// quotient bit a cycle, then the period update.
// One result register: a stalled rsp_ side holds the request side after one item.
// Synchronous active-high reset; csr_ writes are always taken.
`default_nettype none
module step_dir_pulse_generator
   import sdpg_pkg::*;
#(
   parameter int STEP_BITS   = 32,
   parameter int PERIOD_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   sdpg_req_if.sink     req_chan,
   sdpg_rsp_if.source   rsp_chan,
   sdpg_csr_if.sink     csr_chan
);

   req_item_type  req_item;
   rsp_item_type  rsp_item;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   // register writes are always taken and land in the register in the cycle after
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   assign req_item.action       = action_type'(req_chan.action);
   assign req_item.step_count   = req_chan.step_count;
   assign req_item.direction    = req_chan.direction;
   assign req_item.frequency_hz = req_chan.frequency_hz;

   assign rsp_chan.pulse_level     = rsp_item.pulse_level;
   assign rsp_chan.direction_level = rsp_item.direction_level;
   assign rsp_chan.busy_flag       = rsp_item.busy_flag;
   assign rsp_chan.steps_left      = rsp_item.steps_left;
   assign rsp_chan.pulse_event     = rsp_item.pulse_event;

   sdpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sdpg_datapath #(
      .STEP_BITS   (STEP_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

// File: tb/step_dir_pulse_generator_tb.sv
// Self-checking testbench for the step/direction pulse generator.
module step_dir_pulse_generator_tb;
   import sdpg_pkg::*;

   // No transfer on any channel for this many cycles means the block hung.
   localparam int IDLE_LIMIT   = 2000;
   // After this many results the receiver holds off for a long stretch.
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 300;
   // Settling time after the last result.
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_PHASES   = 6;

   logic clock = 1'b0;
   logic reset;

   sdpg_req_if req_chan ();
   sdpg_rsp_if rsp_chan ();
   sdpg_csr_if csr_chan ();

   step_dir_pulse_generator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predicted block state and register copies
   // ---------------------------------------------------------------------
   logic [CLOCK_BITS-1:0] timer_hz;
   logic [PRESC_BITS-1:0] presc_div;

   logic [15:0] presc_cnt;
   logic [15:0] phase_cnt;
   logic [15:0] period_len;
   logic [31:0] steps_rem;
   bit          busy_now;
   bit          running_now;
   bit          dir_now;

   req_item_type pending_cmds[$];   // items waiting for the driver
   rsp_item_type expected_rsp[$];   // predicted results, oldest first
   req_item_type cmd_on_bus;        // item currently offered on req_chan
   int outstanding;                 // queued items whose result has not come back
   int err_count;
   int rsp_seen;
   int idle_cycles;

   int send_gap;
   int rsp_wait;
   bit send_quiet;
   bit rsp_quiet;

   function automatic void reset_pulse_state();
      timer_hz    = CLOCK_RESET;
      presc_div   = '0;
      presc_cnt   = '0;
      phase_cnt   = '0;
      period_len  = 16'hFFFF;
      steps_rem   = '0;
      busy_now    = 1'b0;
      running_now = 1'b0;
      dir_now     = 1'b0;
   endfunction

   // Applies one command to the predicted state and returns the result.
   function automatic rsp_item_type predict_output(req_item_type cmd);
      logic [31:0] raw;
      logic [31:0] neg_raw;
      logic [63:0] mag;
      logic [63:0] quot;
      bit fired;
      rsp_item_type res;
      fired = 1'b0;
      case (cmd.action)
         ACT_TICK: begin
            if (running_now) begin
               if (presc_cnt >= presc_div) begin
                  presc_cnt = '0;
                  if (phase_cnt >= period_len) phase_cnt = '0;
                  else phase_cnt = phase_cnt + 16'd1;
                  // compare event at half period counts a step in a counted run
                  if (phase_cnt == (period_len >> 1)) begin
                     fired = 1'b1;
                     if (busy_now) begin
                        if (steps_rem != 0) steps_rem = steps_rem - 32'd1;
                        if (steps_rem == 0) begin
                           running_now = 1'b0;
                           busy_now    = 1'b0;
                        end
                     end
                  end
               end else begin
                  presc_cnt = presc_cnt + 16'd1;
               end
            end
         end
         ACT_SEND: begin
            // ignored while busy or for a zero count; counters keep their place
            if (cmd.step_count != 0 && !busy_now) begin
               busy_now    = 1'b1;
               steps_rem   = cmd.step_count;
               dir_now     = cmd.direction;
               running_now = 1'b1;
            end
         end
         ACT_FREQ: begin
            raw     = cmd.frequency_hz;
            neg_raw = ~raw + 32'd1;
            dir_now = !raw[31];
            mag     = raw[31] ? 64'(neg_raw) : 64'(raw);
            if (mag == 0) begin
               // zero rate halts output, busy and count stay as they are
               running_now = 1'b0;
            end else begin
               quot = 64'(timer_hz) / ((64'(presc_div) + 64'd1) * mag);
               if (quot <= 1) period_len = 16'd1;
               else if (quot - 1 > 64'hFFFF) period_len = 16'hFFFF;
               else period_len = 16'(quot - 1);
               running_now = 1'b1;
            end
         end
         default: begin
            running_now = 1'b0;
            steps_rem   = '0;
            busy_now    = 1'b0;
         end
      endcase
      res.pulse_level     = running_now && (phase_cnt < (period_len >> 1));
      res.direction_level = dir_now;
      res.busy_flag       = busy_now;
      res.steps_left      = steps_rem;
      res.pulse_event     = fired;
      return res;
   endfunction

   function automatic void enqueue_cmd(action_type act, logic [31:0] steps, logic dir,
                                       logic [31:0] freq);
      req_item_type cmd;
      cmd.action       = act;
      cmd.step_count   = steps;
      cmd.direction    = dir;
      cmd.frequency_hz = freq;
      pending_cmds.push_back(cmd);
      outstanding++;
   endfunction

   // Mostly ticks, with counted runs and rates chosen to give short periods
   // so compare events and run completions happen often; the rest is noise.
   function automatic void enqueue_random_cmd();
      int pick;
      int target;
      logic [63:0] rate;
      logic [31:0] freq;
      pick   = $urandom_range(0, 99);
      target = $urandom_range(2, 12);
      rate   = 64'(timer_hz) / ((64'(presc_div) + 64'd1) * 64'(target + 1));
      if (rate == 0) rate = 1;
      if (rate > 64'h7FFF_FFFF) rate = 64'h7FFF_FFFF;
      freq = $urandom_range(0, 1) ? -32'(rate) : 32'(rate);
      if (pick < 72)
         enqueue_cmd(ACT_TICK, $urandom, $urandom_range(0, 1), $urandom);
      else if (pick < 80)
         enqueue_cmd(ACT_SEND, $urandom_range(1, 6), $urandom_range(0, 1), $urandom);
      else if (pick < 82)
         enqueue_cmd(ACT_SEND, $urandom_range(0, 2) == 0 ? 32'd0 : $urandom,
                     $urandom_range(0, 1), $urandom);
      else if (pick < 92)
         enqueue_cmd(ACT_FREQ, $urandom, $urandom_range(0, 1), freq);
      else if (pick < 95)
         enqueue_cmd(ACT_FREQ, $urandom, $urandom_range(0, 1),
                     $urandom_range(0, 3) == 0 ? 32'd0 : $urandom);
      else
         enqueue_cmd(ACT_STOP, $urandom, $urandom_range(0, 1), $urandom);
   endfunction

   // Per-transfer wait, with occasional stretches of back-to-back traffic.
   function automatic int pick_wait(inout bit quiet);
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 6);
   endfunction

   // Register write; called with the block idle.
   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == CSR_TIMER_CLOCK) timer_hz = value;
      else presc_div = value[PRESC_BITS-1:0];
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued items, predicts each one on its transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rsp.push_back(predict_output(cmd_on_bus));
            send_gap = pick_wait(send_quiet);
         end
         // slot is free when nothing is offered or the offer just went through
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_chan.action       <= cmd_on_bus.action;
               req_chan.step_count   <= cmd_on_bus.step_count;
               req_chan.direction    <= cmd_on_bus.direction;
               req_chan.frequency_hz <= cmd_on_bus.frequency_hz;
               req_chan.valid        <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each result transfer against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result transfer with no prediction pending");
               err_count++;
            end else begin
               want = expected_rsp.pop_front();
               outstanding--;
               if (rsp_chan.pulse_level !== want.pulse_level) begin
                  $error("pulse_level: expected %0d, got %0d",
                         want.pulse_level, rsp_chan.pulse_level);
                  err_count++;
               end
               if (rsp_chan.direction_level !== want.direction_level) begin
                  $error("direction_level: expected %0d, got %0d",
                         want.direction_level, rsp_chan.direction_level);
                  err_count++;
               end
               if (rsp_chan.busy_flag !== want.busy_flag) begin
                  $error("busy_flag: expected %0d, got %0d",
                         want.busy_flag, rsp_chan.busy_flag);
                  err_count++;
               end
               if (rsp_chan.steps_left !== want.steps_left) begin
                  $error("steps_left: expected %0d, got %0d",
                         want.steps_left, rsp_chan.steps_left);
                  err_count++;
               end
               if (rsp_chan.pulse_event !== want.pulse_event) begin
                  $error("pulse_event: expected %0d, got %0d",
                         want.pulse_event, rsp_chan.pulse_event);
                  err_count++;
               end
            end
            rsp_seen++;
            // one long hold-off so the result register backs up into req_chan
            rsp_wait = (rsp_seen == HOLD_AT) ? HOLD_CYCLES : pick_wait(rsp_quiet);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [CLOCK_BITS-1:0] phase_clock [NUM_PHASES];
      logic [PRESC_BITS-1:0] phase_presc [NUM_PHASES];
      int phase_items [NUM_PHASES];
      // register settings per phase: extremes of both registers, zero clock too
      phase_clock = '{30'd1000, 30'h3FFF_FFFF, 30'd0, 30'd1, 30'd180000000, 30'd200000};
      phase_presc = '{16'd0, 16'd3, 16'hFFFF, 16'd0, 16'd1, 16'd7};
      phase_items = '{400, 300, 100, 100, 400, 200};

      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.action       = ACT_TICK;
      req_chan.step_count   = '0;
      req_chan.direction    = 1'b0;
      req_chan.frequency_hz = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = CSR_TIMER_CLOCK;
      csr_chan.data         = '0;
      outstanding = 0;
      err_count   = 0;
      rsp_seen    = 0;
      idle_cycles = 0;
      send_quiet  = 1'b0;
      rsp_quiet   = 1'b0;
      reset_pulse_state();

      // Directed part at reset register values (180 MHz, no prescale).
      enqueue_cmd(ACT_TICK, '0, 1'b0, '0);            // tick while stopped
      enqueue_cmd(ACT_FREQ, '0, 1'b0, '0);            // zero rate: halt, dir clockwise
      enqueue_cmd(ACT_FREQ, '0, 1'b0, 32'hFFFF_FFFF); // -1 Hz: period saturates
      enqueue_cmd(ACT_TICK, '0, 1'b0, '0);
      enqueue_cmd(ACT_TICK, '0, 1'b0, '0);
      enqueue_cmd(ACT_FREQ, '0, 1'b0, 32'h7FFF_FFFF); // quotient 0: period clamps to 1
      enqueue_cmd(ACT_FREQ, '0, 1'b0, 32'h8000_0000); // most negative rate
      repeat (3) enqueue_cmd(ACT_TICK, '0, 1'b0, '0);
      enqueue_cmd(ACT_SEND, 32'd0, 1'b1, '0);         // zero count: ignored
      enqueue_cmd(ACT_SEND, 32'hFFFF_FFFF, 1'b1, '0); // full count, clockwise
      enqueue_cmd(ACT_SEND, 32'd5, 1'b0, '0);         // ignored while busy
      repeat (2) enqueue_cmd(ACT_TICK, '0, 1'b0, '0);
      enqueue_cmd(ACT_STOP, '0, 1'b0, '0);
      enqueue_cmd(ACT_SEND, 32'd3, 1'b0, '0);
      enqueue_cmd(ACT_FREQ, '0, 1'b0, 32'd90000000);  // quotient 2: period 1
      repeat (6) enqueue_cmd(ACT_TICK, '0, 1'b0, '0); // run finishes, busy clears
      enqueue_cmd(ACT_SEND, 32'd2, 1'b1, '0);
      enqueue_cmd(ACT_FREQ, '0, 1'b0, '0);            // halted but still busy
      enqueue_cmd(ACT_TICK, '0, 1'b0, '0);
      enqueue_cmd(ACT_STOP, '0, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Random phases; registers change only once every result is back.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         write_csr(CSR_TIMER_CLOCK, phase_clock[ph]);
         write_csr(CSR_PRESCALER, CSR_DATA_BITS'(phase_presc[ph]));
         for (int n = 0; n < phase_items[ph]; n++) enqueue_random_cmd();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d predicted results never arrived", expected_rsp.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
